// File: hdl/grid_wavefront_distance_unit_defines.svh
// Assertion macros shared by the grid wavefront distance unit.
// Included by the wavefront engine and the top level; no other dependencies.
`ifndef GRID_WAVEFRONT_DISTANCE_UNIT_DEFINES_SVH
`define GRID_WAVEFRONT_DISTANCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GWD_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GWD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GWD_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg)
`define GWD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hdl/gwd_pkg.sv
// Types and constants of the grid wavefront distance unit.
// Used by the wavefront engine, the top level and the bench; depends on nothing.
`timescale 1ns / 1ps

package gwd_pkg;

  localparam int GRID_SIDE        = 7;
  localparam int CELL_COUNT       = GRID_SIDE * GRID_SIDE;
  localparam int UNREACHABLE_COST = 100;
  localparam int CELL_W           = 6;
  localparam int DIST_W           = 7;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = CELL_COUNT;

  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [CELL_COUNT-1:0] mask_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_CELL = 2'd0,
    CFG_FORBIDDEN  = 2'd1,
    CFG_OCCUPIED   = 2'd2,
    CFG_CHECK_OCC  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_REBUILD = 1'b0,
    ACT_READ    = 1'b1
  } action_e;

  // distance map write request from the wavefront engine
  typedef struct packed {
    logic  en;
    cell_t addr;
    dist_t data;
  } gwd_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gwd_wave_stat_t;

endpackage

// File: hdl/gwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the distance map of the grid wavefront distance unit.
`timescale 1ns / 1ps

module gwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gwd_wave.sv
// Wavefront engine: grows the reachable set one distance level at a time and
// writes every cell of the map exactly once. Depends on gwd_pkg.
`timescale 1ns / 1ps
`include "grid_wavefront_distance_unit_defines.svh"

module gwd_wave import gwd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  cell_t          start_cell_i,
  input  mask_t          passable_i,
  output gwd_wr_t        wr_o,
  output gwd_wave_stat_t stat_o
);

  typedef enum logic [2:0] {
    WV_IDLE  = 3'b001,
    WV_DRAIN = 3'b010,
    WV_FILL  = 3'b100
  } wave_state_e;

  wave_state_e state_q, state_d;
  mask_t       visited_q, visited_d;
  mask_t       layer_q, layer_d;
  mask_t       pending_q, pending_d;
  dist_t       level_q, level_d;

  mask_t from_n, from_s, from_w, from_e;
  mask_t grown, next_layer, seed, pending_low;
  cell_t low_idx;

  // neighbors of the current layer, one bit per cell
  for (genvar g = 0; g < CELL_COUNT; g++) begin : g_grow
    localparam int Row = g / GRID_SIDE;
    localparam int Col = g % GRID_SIDE;
    if (Row > 0) begin : g_n
      assign from_n[g] = layer_q[g - GRID_SIDE];
    end else begin : g_no_n
      assign from_n[g] = 1'b0;
    end
    if (Row < GRID_SIDE - 1) begin : g_s
      assign from_s[g] = layer_q[g + GRID_SIDE];
    end else begin : g_no_s
      assign from_s[g] = 1'b0;
    end
    if (Col > 0) begin : g_w
      assign from_w[g] = layer_q[g - 1];
    end else begin : g_no_w
      assign from_w[g] = 1'b0;
    end
    if (Col < GRID_SIDE - 1) begin : g_e
      assign from_e[g] = layer_q[g + 1];
    end else begin : g_no_e
      assign from_e[g] = 1'b0;
    end
  end

  assign grown       = from_n | from_s | from_w | from_e;
  assign next_layer  = grown & passable_i & ~visited_q;
  assign seed        = (start_cell_i < cell_t'(CELL_COUNT)) ? (mask_t'(1) << start_cell_i)
                                                            : '0;
  // isolate lowest pending cell
  assign pending_low = pending_q & (~pending_q + mask_t'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      if (pending_low[i]) begin
        low_idx = low_idx | cell_t'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    layer_d     = layer_q;
    pending_d   = pending_q;
    level_d     = level_q;
    wr_o        = '0;
    stat_o.busy = (state_q != WV_IDLE);
    stat_o.done = 1'b0;
    unique case (state_q)
      WV_IDLE: begin
        if (start_i) begin
          visited_d = seed;
          layer_d   = seed;
          pending_d = seed;
          level_d   = '0;
          state_d   = WV_DRAIN;
        end
      end
      WV_DRAIN: begin
        if (|pending_q) begin
          wr_o.en   = 1'b1;
          wr_o.addr = low_idx;
          wr_o.data = level_q;
          pending_d = pending_q & ~pending_low;
        end else if (next_layer == '0 || level_q == dist_t'(UNREACHABLE_COST - 1)) begin
          // everything not reached yet stays unreachable
          pending_d = ~visited_q;
          state_d   = WV_FILL;
        end else begin
          layer_d   = next_layer;
          pending_d = next_layer;
          visited_d = visited_q | next_layer;
          level_d   = level_q + 1'b1;
        end
      end
      WV_FILL: begin
        if (|pending_q) begin
          wr_o.en   = 1'b1;
          wr_o.addr = low_idx;
          wr_o.data = dist_t'(UNREACHABLE_COST);
          pending_d = pending_q & ~pending_low;
        end else begin
          stat_o.done = 1'b1;
          state_d     = WV_IDLE;
        end
      end
      default: state_d = WV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= WV_IDLE;
      visited_q <= '0;
      layer_q   <= '0;
      pending_q <= '0;
      level_q   <= '0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      layer_q   <= layer_d;
      pending_q <= pending_d;
      level_q   <= level_d;
    end
  end

  `GWD_ASSERT_IMPLY(a_wr_one_cell, clk_i, rst_ni, wr_o.en, $onehot(pending_low), "write without single pending cell")
  `GWD_ASSERT_NEXT(a_visited_grows, clk_i, rst_ni, state_q == WV_DRAIN, (visited_q & $past(visited_q)) == $past(visited_q), "visited set lost a cell")
  `GWD_ASSERT_IMPLY(a_level_bound, clk_i, rst_ni, stat_o.busy, level_q < dist_t'(UNREACHABLE_COST), "level reached unreachable cost")

endmodule

// File: hdl/grid_wavefront_distance_unit.sv
// Grid wavefront distance unit: a read item goes from acceptance to a result in the output
// register through its steps (accept with the map read issued, capture, hand-off); a read
// before the first rebuild or of a cell outside the grid skips the map. A rebuild item makes
// 49 map writes, one per cycle through the single write port of the map memory, level by
// level of the wavefront on the 7x7 grid. The map reads as unreachable everywhere after
// reset until the first rebuild; no clearing pass is run. One item is worked on at a time;
// the next one is accepted while the previous result waits in the output register.
// Depends on gwd_pkg, gwd_ram and gwd_wave.
`timescale 1ns / 1ps
`include "grid_wavefront_distance_unit_defines.svh"

module grid_wavefront_distance_unit import gwd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [5:0] cell_req
  input  logic [0:0]             s_axis_tuser,   // [0] action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [6:0] distance
  output logic [0:0]             m_axis_tuser    // [0] reachable
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_READ  = 4'b0100,
    ST_RESP  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  cell_t      start_cell_q;
  mask_t      forbidden_q, occupied_q;
  logic       check_occ_q;
  logic       built_q, built_d;
  dist_t      res_dist_q, res_dist_d;
  logic       res_reach_q, res_reach_d;
  logic       out_valid_q, out_valid_d;
  dist_t      out_dist_q, out_dist_d;
  logic       out_reach_q, out_reach_d;

  logic           in_acc, out_load, ram_re, wave_start;
  cell_t          in_cell;
  action_e        in_action;
  mask_t          passable;
  dist_t          ram_rdata;
  gwd_wr_t        wave_wr;
  gwd_wave_stat_t wave_stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cell_q <= '0;
      forbidden_q  <= '0;
      occupied_q   <= '0;
      check_occ_q  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_START_CELL: start_cell_q <= cfg_data_i[CELL_W-1:0];
        CFG_FORBIDDEN:  forbidden_q  <= cfg_data_i;
        CFG_OCCUPIED:   occupied_q   <= cfg_data_i;
        CFG_CHECK_OCC:  check_occ_q  <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  assign passable = ~(forbidden_q | (occupied_q & {CELL_COUNT{check_occ_q}}));

  gwd_wave u_wave (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (wave_start),
    .start_cell_i(start_cell_q),
    .passable_i  (passable),
    .wr_o        (wave_wr),
    .stat_o      (wave_stat)
  );

  // reads only happen in idle, writes only during a rebuild: no overlap
  gwd_ram #(
    .Width(DIST_W),
    .Depth(CELL_COUNT)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (wave_wr.en),
    .waddr_i(wave_wr.addr),
    .wdata_i(wave_wr.data),
    .re_i   (ram_re),
    .raddr_i(in_cell),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_action     = action_e'(s_axis_tuser[0]);
  assign in_cell       = s_axis_tdata[CELL_W-1:0];
  assign out_load      = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    built_d     = built_q;
    res_dist_d  = res_dist_q;
    res_reach_d = res_reach_q;
    ram_re      = 1'b0;
    wave_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_REBUILD) begin
            wave_start = 1'b1;
            state_d    = ST_BUILD;
          end else if (built_q && in_cell < cell_t'(CELL_COUNT)) begin
            ram_re  = 1'b1;
            state_d = ST_READ;
          end else begin
            res_dist_d  = dist_t'(UNREACHABLE_COST);
            res_reach_d = 1'b0;
            state_d     = ST_RESP;
          end
        end
      end
      ST_BUILD: begin
        if (wave_stat.done) begin
          built_d     = 1'b1;
          res_dist_d  = '0;
          res_reach_d = 1'b0;
          state_d     = ST_RESP;
        end
      end
      ST_READ: begin
        res_dist_d  = ram_rdata;
        res_reach_d = (ram_rdata < dist_t'(UNREACHABLE_COST));
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_dist_d  = out_dist_q;
    out_reach_d = out_reach_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_dist_d  = res_dist_q;
      out_reach_d = res_reach_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_dist_q  <= res_dist_d;
    res_reach_q <= res_reach_d;
    out_dist_q  <= out_dist_d;
    out_reach_q <= out_reach_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_dist_q};
  assign m_axis_tuser  = out_reach_q;

  `GWD_ASSERT_IMPLY(a_no_read_in_build, clk_i, rst_ni, ram_re, !wave_stat.busy, "map read during rebuild")
  `GWD_ASSERT_IMPLY(a_done_in_build, clk_i, rst_ni, wave_stat.done, state_q == ST_BUILD, "rebuild done outside build")
  `GWD_ASSERT_IMPLY(a_reach_bound, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], out_dist_q < dist_t'(UNREACHABLE_COST), "reachable result with unreachable distance")
  `GWD_ASSERT_NEXT(a_resp_hold, clk_i, rst_ni, state_q == ST_RESP && out_valid_q && !m_axis_tready, state_q == ST_RESP, "result dropped while output stalled")

endmodule

// File: tb/tb_grid_wavefront_distance_unit.sv
// Self-checking bench for grid_wavefront_distance_unit: directed and random rebuild/read items
// checked against an in-bench distance map model, with random stalls on both streams.
// Depends on gwd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_grid_wavefront_distance_unit;
  import gwd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1300;

  typedef struct packed {
    dist_t distance;
    logic  reachable;
  } cell_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [5:0] cell_req
  logic [0:0]             s_axis_tuser;   // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [7:0]             m_axis_tdata;   // [6:0] distance
  logic [0:0]             m_axis_tuser;   // [0] reachable

  // shadow of the configuration and the distance map
  cell_t start_shadow;
  mask_t forbidden_shadow;
  mask_t occupied_shadow;
  logic  check_occ_shadow;
  dist_t dist_shadow [CELL_COUNT];

  cell_result_t pending_cell_results[$];
  int           mismatches;
  int           stall_cycles;
  int           rx_hold_left;
  bit           idle_en;

  grid_wavefront_distance_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic bit passable(int idx);
    if (forbidden_shadow[idx]) return 1'b0;
    if (check_occ_shadow && occupied_shadow[idx]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit relax(int src, int dst);
    int cand;
    cand = int'(dist_shadow[src]) + 1;
    if (!passable(dst)) return 1'b0;
    if (int'(dist_shadow[dst]) > cand) begin
      dist_shadow[dst] = dist_t'(cand);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void rebuild_distance_shadow();
    bit changed;
    int here;
    for (int i = 0; i < CELL_COUNT; i++) dist_shadow[i] = dist_t'(UNREACHABLE_COST);
    // an out-of-range start seeds nothing
    if (start_shadow < CELL_COUNT) dist_shadow[start_shadow] = '0;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int row = 0; row < GRID_SIDE; row++) begin
        for (int col = 0; col < GRID_SIDE; col++) begin
          here = row * GRID_SIDE + col;
          if (row > 0 && relax(here, here - GRID_SIDE)) changed = 1'b1;
          if (col < GRID_SIDE - 1 && relax(here, here + 1)) changed = 1'b1;
          if (row < GRID_SIDE - 1 && relax(here, here + GRID_SIDE)) changed = 1'b1;
          if (col > 0 && relax(here, here - 1)) changed = 1'b1;
        end
      end
    end
  endfunction

  function automatic cell_result_t wavefront_predict(action_e act, cell_t req_cell);
    cell_result_t res;
    if (act == ACT_REBUILD) begin
      rebuild_distance_shadow();
      res.distance  = '0;
      res.reachable = 1'b0;
    end else if (req_cell < CELL_COUNT) begin
      res.distance  = dist_shadow[req_cell];
      res.reachable = (dist_shadow[req_cell] < UNREACHABLE_COST);
    end else begin
      res.distance  = dist_t'(UNREACHABLE_COST);
      res.reachable = 1'b0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic mask_t random_mask();
    mask_t m;
    int    mode;
    int    density;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    density = $urandom_range(5, 40);
    for (int i = 0; i < CELL_COUNT; i++) m[i] = ($urandom_range(0, 99) < density);
    return m;
  endfunction

  function automatic cell_t random_cell();
    if ($urandom_range(0, 9) == 0) return cell_t'($urandom_range(CELL_COUNT, 63));
    return cell_t'($urandom_range(0, CELL_COUNT - 1));
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic send_item(action_e act, cell_t req_cell);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, req_cell};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_cell_results.push_back(wavefront_predict(act, req_cell));
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cell_results.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_START_CELL: start_shadow     = data[CELL_W-1:0];
      CFG_FORBIDDEN:  forbidden_shadow = data;
      CFG_OCCUPIED:   occupied_shadow  = data;
      CFG_CHECK_OCC:  check_occ_shadow = data[0];
      default: ;
    endcase
  endtask

  task automatic program_config(cell_t start, mask_t forb, mask_t occ, logic chk);
    write_reg(CFG_START_CELL, CFG_DATA_W'(start));
    write_reg(CFG_FORBIDDEN, forb);
    write_reg(CFG_OCCUPIED, occ);
    write_reg(CFG_CHECK_OCC, CFG_DATA_W'(chk));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_after_reset();
    // map reads unreachable before any rebuild, then a rebuild on the reset config
    send_item(ACT_READ, 6'd0);
    send_item(ACT_READ, 6'd48);
    send_item(ACT_READ, 6'd49);
    send_item(ACT_READ, 6'd63);
    send_item(ACT_REBUILD, 6'd63);
    send_item(ACT_READ, 6'd0);
    send_item(ACT_READ, 6'd6);
    send_item(ACT_READ, 6'd48);
    send_item(ACT_READ, 6'd24);
    wait_idle();
  endtask

  task automatic test_masks();
    mask_t col3;
    col3 = '0;
    for (int r = 0; r < GRID_SIDE; r++) if (r != 3) col3[r * GRID_SIDE + 3] = 1'b1;

    // everything forbidden: only the start cell is reached
    program_config(6'd48, '1, '0, 1'b1);
    send_item(ACT_REBUILD, 6'd0);
    send_item(ACT_READ, 6'd48);
    send_item(ACT_READ, 6'd47);
    wait_idle();

    // start beyond the grid seeds nothing
    program_config(6'd63, '0, '1, 1'b0);
    send_item(ACT_REBUILD, 6'd5);
    send_item(ACT_READ, 6'd0);
    wait_idle();

    // forbidden start still spreads; column 3 occupied except the start row
    program_config(6'd24, mask_t'(1) << 24, col3, 1'b1);
    send_item(ACT_REBUILD, 6'd0);
    send_item(ACT_READ, 6'd3);
    send_item(ACT_READ, 6'd2);
    wait_idle();
    program_config(6'd24, mask_t'(1) << 24, col3, 1'b0);
    send_item(ACT_REBUILD, 6'd0);
    send_item(ACT_READ, 6'd3);
    wait_idle();
  endtask

  task automatic test_backpressure();
    idle_en      = 1'b0;
    rx_hold_left = 300;
    program_config(6'd0, '0, '0, 1'b1);
    send_item(ACT_REBUILD, 6'd0);
    for (int i = 0; i < 10; i++) send_item(ACT_READ, cell_t'($urandom_range(0, 63)));
    wait_idle();
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      program_config(($urandom_range(0, 6) == 0) ? cell_t'($urandom_range(CELL_COUNT, 63))
                                                 : cell_t'($urandom_range(0, CELL_COUNT - 1)),
                     random_mask(), random_mask(), logic'($urandom_range(0, 1)));
      idle_en = ($urandom_range(0, 3) != 0);
      send_item(ACT_REBUILD, cell_t'($urandom_range(0, 63)));
      n = $urandom_range(30, 70);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 8) send_item(ACT_REBUILD, cell_t'($urandom_range(0, 63)));
        else send_item(ACT_READ, random_cell());
      end
      sent += n + 1;
    end
    wait_idle();
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- processes

  // result sink: random stalls plus a requested long hold-off
  initial begin
    m_axis_tready <= 1'b0;
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (stall_cycles > 0) begin
        m_axis_tready <= 1'b0;
        stall_cycles--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_cycles = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cell_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: distance %0d reachable %0d",
                                m_axis_tdata[DIST_W-1:0], m_axis_tuser[0]));
      end else begin
        want = pending_cell_results.pop_front();
        if (m_axis_tdata[DIST_W-1:0] !== want.distance)
          note_mismatch($sformatf("distance: expected %0d, got %0d",
                                  want.distance, m_axis_tdata[DIST_W-1:0]));
        if (m_axis_tuser[0] !== want.reachable)
          note_mismatch($sformatf("reachable: expected %0d, got %0d",
                                  want.reachable, m_axis_tuser[0]));
      end
    end
  end

  // watchdog: cycles without any accepted item on any channel
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_grid_wavefront_distance_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index_i   <= CFG_START_CELL;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_REBUILD;
    mismatches       = 0;
    rx_hold_left     = 0;
    idle_en          = 1'b1;
    start_shadow     = '0;
    forbidden_shadow = '0;
    occupied_shadow  = '0;
    check_occ_shadow = 1'b1;
    for (int i = 0; i < CELL_COUNT; i++) dist_shadow[i] = dist_t'(UNREACHABLE_COST);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_masks();
    test_backpressure();
    test_random();

    // tail: anything arriving now is flagged by the checker
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_grid_wavefront_distance_unit: PASS");
    end else begin
      $display("tb_grid_wavefront_distance_unit: FAIL");
    end
    $finish;
  end

endmodule

// File: grid_wavefront_distance_unit.f
+incdir+hdl
hdl/gwd_pkg.sv
hdl/gwd_ram.sv
hdl/gwd_wave.sv
hdl/grid_wavefront_distance_unit.sv
tb/tb_grid_wavefront_distance_unit.sv
